>>> rtl/core/rc_pkg.sv
// rc_pkg: shared types, character constants and digit mapping for the radix converter
// no dependencies

package rc_pkg;

  localparam int unsigned BASE_WIDTH  = 6;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned OUT_WIDTH   = 7;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [BASE_WIDTH-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_WIDTH-1:0] SRC_BASE_RESET = 6'd10;
  localparam logic [BASE_WIDTH-1:0] TGT_BASE_RESET = 6'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

  localparam logic [CHAR_WIDTH-1:0] CHAR_0  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_9  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LA = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LZ = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UA = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UZ = 8'h5A;
  localparam logic [BASE_WIDTH-1:0] DIGIT_LIMIT = 6'd9;
  localparam logic [BASE_WIDTH-1:0] LETTER_BASE = 6'd10;

  typedef struct packed {
    logic busy;
    logic done;
  } rc_div_stat_t;

  function automatic logic [BASE_WIDTH-1:0] clamp_base(input logic [BASE_WIDTH-1:0] b);
    logic [BASE_WIDTH-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic logic [BASE_WIDTH-1:0] char_value(input logic [CHAR_WIDTH-1:0] c);
    logic [CHAR_WIDTH-1:0] t;
    t = '0;
    if (c >= CHAR_0 && c <= CHAR_9) t = c - CHAR_0;
    else if (c >= CHAR_LA && c <= CHAR_LZ) t = c - CHAR_LA + CHAR_WIDTH'(LETTER_BASE);
    else if (c >= CHAR_UA && c <= CHAR_UZ) t = c - CHAR_UA + CHAR_WIDTH'(LETTER_BASE);
    return t[BASE_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_WIDTH-1:0] digit_char(input logic [BASE_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] t;
    if (d <= DIGIT_LIMIT) t = CHAR_0 + CHAR_WIDTH'(d);
    else t = CHAR_UA + CHAR_WIDTH'(d - LETTER_BASE);
    return t[OUT_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/core/rc_in_if.sv
// rc_in_if: valid/ready channel carrying one source character per item
// no dependencies

interface rc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

>>> rtl/core/rc_out_if.sv
// rc_out_if: valid/ready channel carrying one result digit per item
// no dependencies

interface rc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

>>> rtl/core/rc_divider.sv
// rc_divider: restoring divider, one quotient bit per cycle, by a small base
// depends on rc_pkg

module rc_divider #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [WIDTH-1:0]                    dividend,
  input  logic [rc_pkg::BASE_WIDTH-1:0]       divisor,
  output logic [WIDTH-1:0]                    quotient,
  output logic [rc_pkg::BASE_WIDTH-1:0]       remainder,
  output rc_pkg::rc_div_stat_t                stat
);
  import rc_pkg::*;

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [CNT_W-1:0]      cnt;
  logic [BASE_WIDTH-1:0] dvs;
  logic [BASE_WIDTH:0]   trial;
  logic                  fits;

  assign trial = {remainder, quotient[WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
    end else if (stat.busy) begin
      stat.done <= (cnt == '0);
      stat.busy <= (cnt != '0);
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt       <= CNT_W'(WIDTH - 1);
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (stat.busy) begin
      cnt      <= cnt - 1'b1;
      quotient <= {quotient[WIDTH-2:0], fits};
      if (fits) remainder <= BASE_WIDTH'(trial - {1'b0, dvs});
      else remainder <= trial[BASE_WIDTH-1:0];
    end
  end

endmodule

>>> rtl/core/radix_converter.sv
// radix_converter: ascii digit string in one base to ascii digit string in another
// depends on rc_pkg, rc_in_if, rc_out_if, rc_divider
//
//   channel  dir  payload             item
//   stream   in   in_char, in_last    one source character
//   result   out  out_char, out_last  one target digit
//   cfg      in   cfg_we/index/data   base register write
//
// a character without in_last is taken while idle and multiply-added into the accumulator
// a last character starts conversion: each target digit is one run of the bit-serial divider,
// up to MAX_DIGITS digits, then each digit is read out through the FETCH and LOAD states
// stream is not ready from a last character until the final digit sits in the output register
// synchronous active-high reset; readout waits in LOAD while a result digit is held unaccepted

module radix_converter #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc_pkg::BASE_WIDTH-1:0]  cfg_data,
  rc_in_if.sink                          stream,
  rc_out_if.source                       result
);
  import rc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW = $clog2(MAX_DIGITS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_FETCH = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t                  state;
  logic [BASE_WIDTH-1:0]   source_base;
  logic [BASE_WIDTH-1:0]   target_base;
  logic [VALUE_WIDTH-1:0]  accumulator;
  logic [CW-1:0]           digit_count;
  logic [IW-1:0]           rd_ptr;
  logic [BASE_WIDTH-1:0]   digit_store [MAX_DIGITS];
  logic [BASE_WIDTH-1:0]   rd_data;

  logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0]  acc_next;
  logic                    take;
  logic                    div_start;
  logic [VALUE_WIDTH-1:0]  div_dividend;
  logic [VALUE_WIDTH-1:0]  quotient;
  logic [BASE_WIDTH-1:0]   remainder;
  rc_div_stat_t            div_stat;
  logic                    div_more;
  logic                    out_free;

  assign stream.ready = (state == S_IDLE);
  assign take         = stream.valid && stream.ready;
  assign prod         = {{BASE_WIDTH{1'b0}}, accumulator}
                      * {{VALUE_WIDTH{1'b0}}, clamp_base(source_base)};
  assign acc_next     = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(char_value(stream.in_char));
  assign div_more     = (quotient != '0) && (digit_count != CW'(MAX_DIGITS - 1));
  assign div_start    = (take && stream.in_last) || (state == S_DIV && div_stat.done && div_more);
  assign div_dividend = (state == S_IDLE) ? acc_next : quotient;
  assign out_free     = !result.valid || result.ready;

  rc_divider #(.WIDTH(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (clamp_base(target_base)),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // base registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SRC_BASE_RESET;
      target_base <= TGT_BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_BASE: source_base <= cfg_data;
        REG_TARGET_BASE: target_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      accumulator <= '0;
      digit_count <= '0;
      rd_ptr      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (stream.in_last) begin
              accumulator <= '0;
              digit_count <= '0;
              state       <= S_DIV;
            end else begin
              accumulator <= acc_next;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            digit_count <= digit_count + 1'b1;
            if (!div_more) begin
              rd_ptr <= digit_count[IW-1:0];
              state  <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_LOAD;
        S_LOAD: begin
          if (out_free) begin
            if (rd_ptr == '0) begin
              state <= S_IDLE;
            end else begin
              rd_ptr <= rd_ptr - 1'b1;
              state  <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_stat.done) digit_store[digit_count[IW-1:0]] <= remainder;
    rd_data <= digit_store[rd_ptr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_LOAD && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      result.out_char <= digit_char(rd_data);
      result.out_last <= (rd_ptr == '0);
    end
  end

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside conversion");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && out_free && rd_ptr == '0) |=> (state == S_IDLE && result.out_last))
    else $error("final digit not flagged or sequencer not idle");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.out_char >= 7'h30 && result.out_char <= 7'h39)
                   || (result.out_char >= 7'h41 && result.out_char <= 7'h5A)))
    else $error("result character outside digit range");
`endif

endmodule
